@@ rtl/dogx_pkg.sv @@
// Shared types and constants for the DoG extremum detector.
// Used by the front, queue, back and top-level modules; depends on nothing.
package dogx_pkg;

  // Configuration register indexes and widths
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam int unsigned CFG_BITS     = 13;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] LINE_WIDTH_RST   = 13'd640;
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [CFG_BITS-1:0] MIN_SIZE         = 13'd3;
  localparam logic [CFG_BITS-1:0] MAX_HEIGHT       = 13'd4096;

  // Result coordinates
  localparam int unsigned POS_BITS = 12;

  // Front-to-back queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;
  localparam int unsigned QCW    = 3;

  // 3x3x3 patch: plane-major, then row, then column
  localparam int unsigned PATCH_N      = 27;
  localparam int unsigned PATCH_CENTER = 13;

  typedef struct packed {
    logic [POS_BITS-1:0] x;
    logic [POS_BITS-1:0] y;
  } pos_t;

  localparam int unsigned POS_T_BITS = 2 * POS_BITS;

endpackage

@@ rtl/dogx_fifo.sv @@
// Short register queue between the front and back halves of the detector.
// Depends on dogx_pkg for depth and pointer widths.
module dogx_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [WIDTH-1:0]        push_data_i,
  input  logic                    pop_i,
  output logic                    valid_o,
  output logic [WIDTH-1:0]        data_o,
  output logic [dogx_pkg::QCW-1:0] count_o
);

  logic [WIDTH-1:0]         entry_q [dogx_pkg::QDEPTH];
  logic [dogx_pkg::QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [dogx_pkg::QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [dogx_pkg::QCW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q != dogx_pkg::QCW'(dogx_pkg::QDEPTH))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dogx_pkg::QCW'(dogx_pkg::QDEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

@@ rtl/dogx_front.sv @@
// Front half: configuration, position tracking, DoG forming, line store and
// column window. Builds the 3x3x3 patch and pushes tested centres to the queue.
// Depends on dogx_pkg.
module dogx_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned QW         = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dogx_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [dogx_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [PIXEL_BITS-1:0]             gauss_level0_i,
  input  logic [PIXEL_BITS-1:0]             gauss_level1_i,
  input  logic [PIXEL_BITS-1:0]             gauss_level2_i,
  input  logic [PIXEL_BITS-1:0]             gauss_level3_i,
  input  logic [dogx_pkg::QCW-1:0]          q_count_i,
  output logic                              push_o,
  output logic [QW-1:0]                     push_data_o
);

  localparam int unsigned DW = PIXEL_BITS + 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned SW = (CW + 1 > dogx_pkg::CFG_BITS) ? CW + 1 : dogx_pkg::CFG_BITS;
  localparam int unsigned LW = 6 * DW;
  localparam int unsigned HB = dogx_pkg::CFG_BITS;

  // Configuration
  logic [dogx_pkg::CFG_BITS-1:0] line_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= dogx_pkg::LINE_WIDTH_RST;
      frame_height_q <= dogx_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dogx_pkg::CFG_LINE_WIDTH:   line_width_q   <= cfg_wdata_i;
        dogx_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
      endcase
    end
  end

  // Position of the incoming word
  logic [CW-1:0]                col_q, col_d;
  logic [dogx_pkg::POS_BITS-1:0] row_q, row_d;
  logic [SW-1:0] lw_ext, width_eff, col_ext, x_ext, x_inc;
  logic [HB-1:0] height_eff, y_ext, y_inc;
  logic [CW-1:0] x;
  logic          wrap, test, accept;
  dogx_pkg::pos_t pos;

  always_comb begin
    lw_ext = SW'(line_width_q);
    if (lw_ext < SW'(dogx_pkg::MIN_SIZE)) begin
      width_eff = SW'(dogx_pkg::MIN_SIZE);
    end else if (lw_ext > SW'(MAX_WIDTH)) begin
      width_eff = SW'(MAX_WIDTH);
    end else begin
      width_eff = lw_ext;
    end
    if (frame_height_q < dogx_pkg::MIN_SIZE) begin
      height_eff = dogx_pkg::MIN_SIZE;
    end else if (frame_height_q > dogx_pkg::MAX_HEIGHT) begin
      height_eff = dogx_pkg::MAX_HEIGHT;
    end else begin
      height_eff = frame_height_q;
    end

    // pull the column back inside a line that has shrunk
    col_ext = SW'(col_q);
    x       = (col_ext >= width_eff) ? CW'(width_eff - SW'(1)) : col_q;
    x_ext   = SW'(x);
    x_inc   = x_ext + SW'(1);
    y_ext   = HB'(row_q);
    y_inc   = y_ext + HB'(1);
    wrap    = (x_inc >= width_eff);

    if (wrap) begin
      col_d = '0;
      row_d = (y_inc >= height_eff) ? '0 : row_q + 1'b1;
    end else begin
      col_d = CW'(x_inc);
      row_d = (y_ext >= height_eff) ? dogx_pkg::POS_BITS'(height_eff - HB'(1)) : row_q;
    end

    test  = (x_ext >= SW'(2)) && (row_q >= dogx_pkg::POS_BITS'(2));
    pos.x = dogx_pkg::POS_BITS'(x_ext - SW'(1));
    pos.y = row_q - 1'b1;
  end

  // Admit a word only if the queue is sure to have room when it leaves stage 1
  logic                     s1_valid_q;
  logic [dogx_pkg::QCW:0]   credit;

  assign credit     = (dogx_pkg::QCW + 1)'(q_count_i) + (dogx_pkg::QCW + 1)'(s1_valid_q);
  assign in_ready_o = (credit <= (dogx_pkg::QCW + 1)'(dogx_pkg::QDEPTH - 1));
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // DoG planes, exact signed differences
  logic [3*DW-1:0] cur;

  assign cur[0*DW +: DW] = DW'(gauss_level1_i) - DW'(gauss_level0_i);
  assign cur[1*DW +: DW] = DW'(gauss_level2_i) - DW'(gauss_level1_i);
  assign cur[2*DW +: DW] = DW'(gauss_level3_i) - DW'(gauss_level2_i);

  // Stage 1 registers
  logic [CW-1:0]   s1_x_q;
  logic            s1_test_q;
  dogx_pkg::pos_t  s1_pos_q;
  logic [3*DW-1:0] s1_cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q    <= x;
      s1_test_q <= test;
      s1_pos_q  <= pos;
      s1_cur_q  <= cur;
    end
  end

  // Line store: low half is the row above, high half the row two above
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] line_rd_q;
  logic [LW-1:0] line_wr;

  assign line_wr = {line_rd_q[3*DW-1:0], s1_cur_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_rd_q <= line_mem[x];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_x_q] <= line_wr;
    end
  end

  // Column window and patch
  logic [DW-1:0] win_q [3][3][2];
  logic [DW-1:0] col2  [3][3];
  logic [dogx_pkg::PATCH_N*DW-1:0] patch;

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      col2[p][0] = line_rd_q[(3 + p)*DW +: DW];
      col2[p][1] = line_rd_q[p*DW +: DW];
      col2[p][2] = s1_cur_q[p*DW +: DW];
      for (int r = 0; r < 3; r++) begin
        patch[(p*9 + r*3 + 0)*DW +: DW] = win_q[p][r][0];
        patch[(p*9 + r*3 + 1)*DW +: DW] = win_q[p][r][1];
        patch[(p*9 + r*3 + 2)*DW +: DW] = col2[p][r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < 3; p++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[p][r][0] <= '0;
          win_q[p][r][1] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      // advance the window by one column
      for (int p = 0; p < 3; p++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[p][r][0] <= win_q[p][r][1];
          win_q[p][r][1] <= col2[p][r];
        end
      end
    end
  end

  assign push_o      = s1_valid_q && s1_test_q;
  assign push_data_o = {s1_pos_q, patch};

`ifndef ASSERT_OFF
  a_line_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s1_valid_q |-> x != s1_x_q)
    else $error("line store read and write hit the same column");
  a_centre_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> s1_pos_q.x != '0 && s1_pos_q.y != '0)
    else $error("border centre pushed for testing");
`endif

endmodule

@@ rtl/dogx_back.sv @@
// Back half: takes a patch from the queue, compares the centre with its 26
// neighbours and holds the result in the output register. Depends on dogx_pkg.
module dogx_back #(
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned QW         = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  logic [QW-1:0]                  q_data_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dogx_pkg::POS_BITS-1:0]  center_x_o,
  output logic [dogx_pkg::POS_BITS-1:0]  center_y_o,
  output logic                           is_extremum_o,
  output logic                           is_maximum_o
);

  localparam int unsigned DW = PIXEL_BITS + 1;

  dogx_pkg::pos_t                  pos;
  logic [dogx_pkg::PATCH_N*DW-1:0] patch;
  logic signed [DW-1:0]            centre, v;
  logic [dogx_pkg::PATCH_N-1:0]    gt, lt;
  logic                            is_max, is_min, take;

  assign pos   = q_data_i[QW-1 -: dogx_pkg::POS_T_BITS];
  assign patch = q_data_i[dogx_pkg::PATCH_N*DW-1:0];

  always_comb begin
    centre = $signed(patch[dogx_pkg::PATCH_CENTER*DW +: DW]);
    v      = '0;
    for (int k = 0; k < dogx_pkg::PATCH_N; k++) begin
      v     = $signed(patch[k*DW +: DW]);
      gt[k] = (k != dogx_pkg::PATCH_CENTER) && (v > centre);
      lt[k] = (k != dogx_pkg::PATCH_CENTER) && (v < centre);
    end
    is_max = ~|gt;
    is_min = ~|lt;
  end

  logic                           out_valid_q;
  logic [dogx_pkg::POS_BITS-1:0]  cx_q, cy_q;
  logic                           ext_q, max_q;

  // load whenever the register is empty or its word is being taken
  assign take  = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cx_q  <= pos.x;
      cy_q  <= pos.y;
      ext_q <= is_max ^ is_min;
      max_q <= is_max && !is_min;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign center_x_o    = cx_q;
  assign center_y_o    = cy_q;
  assign is_extremum_o = ext_q;
  assign is_maximum_o  = max_q;

endmodule

@@ rtl/dog_extremum_detector_unit.sv @@
// DoG extremum detector, 3x3x3 neighbourhood. Takes one word of four smoothed
// levels per cycle while in_ready_o is high and returns one result per interior
// centre; its word goes through stage 1 (line store read), the queue (patch) and
// the output register (compare). Sustained rate is one word per cycle while the
// output is not stalled: the single line store is read once and written once per
// word, and a four-entry queue decouples the front from the output, so a stalled
// output backs up into in_ready_o once queued words plus the stage-1 word would
// fill the queue. The line store has no reset and no clearing pass; it holds no
// valid data until the first rows of a frame have gone through.
module dog_extremum_detector_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dogx_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [dogx_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [PIXEL_BITS-1:0]             gauss_level0_i,
  input  logic [PIXEL_BITS-1:0]             gauss_level1_i,
  input  logic [PIXEL_BITS-1:0]             gauss_level2_i,
  input  logic [PIXEL_BITS-1:0]             gauss_level3_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dogx_pkg::POS_BITS-1:0]     center_x_o,
  output logic [dogx_pkg::POS_BITS-1:0]     center_y_o,
  output logic                              is_extremum_o,
  output logic                              is_maximum_o
);

  localparam int unsigned DW = PIXEL_BITS + 1;
  localparam int unsigned QW = dogx_pkg::POS_T_BITS + dogx_pkg::PATCH_N * DW;

  logic                     push, pop, q_valid;
  logic [QW-1:0]            push_data, q_data;
  logic [dogx_pkg::QCW-1:0] q_count;

  dogx_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .QW         (QW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .gauss_level0_i (gauss_level0_i),
    .gauss_level1_i (gauss_level1_i),
    .gauss_level2_i (gauss_level2_i),
    .gauss_level3_i (gauss_level3_i),
    .q_count_i      (q_count),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  dogx_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  dogx_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .QW         (QW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .center_x_o    (center_x_o),
    .center_y_o    (center_y_o),
    .is_extremum_o (is_extremum_o),
    .is_maximum_o  (is_maximum_o)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking bench for dog_extremum_detector_unit: drives frames of four-level words,
// predicts every centre verdict and compares each result word against it.
// Depends on dogx_pkg and the RTL top level only.
module tb;

  localparam int LINE_MAX      = 4096;
  localparam int HEIGHT_MAX    = 4096;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_WORDS  = 1200;
  localparam int HOLD_OFF_LONG = 300;
  localparam int WIDE_WORDS    = 200;
  localparam int TALL_ROWS     = 60;

  typedef logic signed [16:0] dog_t;
  typedef logic [3:0][15:0] gauss_word_t;

  typedef struct packed {
    logic [dogx_pkg::POS_BITS-1:0] cx;
    logic [dogx_pkg::POS_BITS-1:0] cy;
    logic                          ext;
    logic                          maxm;
  } centre_verdict_t;

  typedef enum int {
    FILL_NOISE,
    FILL_TIES,
    FILL_FLAT,
    FILL_SPIKES,
    FILL_PEAK,
    FILL_DIP
  } fill_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we;
  logic [dogx_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [dogx_pkg::CFG_BITS-1:0]     cfg_wdata;
  logic                              in_valid;
  logic                              in_ready;
  logic [15:0]                       gauss_level0;
  logic [15:0]                       gauss_level1;
  logic [15:0]                       gauss_level2;
  logic [15:0]                       gauss_level3;
  logic                              out_valid;
  logic                              out_ready;
  logic [dogx_pkg::POS_BITS-1:0]     center_x;
  logic [dogx_pkg::POS_BITS-1:0]     center_y;
  logic                              is_extremum;
  logic                              is_maximum;

  // Predictor state
  logic [dogx_pkg::CFG_BITS-1:0] cfg_width = dogx_pkg::LINE_WIDTH_RST;
  logic [dogx_pkg::CFG_BITS-1:0] cfg_height = dogx_pkg::FRAME_HEIGHT_RST;
  dog_t line_above [LINE_MAX][3];
  dog_t line_two_above [LINE_MAX][3];
  dog_t win [3][3][2] = '{default: '0};
  int col_pos = 0;
  int row_pos = 0;
  centre_verdict_t expected_verdicts [$];

  gauss_word_t frame_base = '0;
  int words_sent = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  dog_extremum_detector_unit #(
    .MAX_WIDTH (4096),
    .PIXEL_BITS(16)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .gauss_level0_i(gauss_level0),
    .gauss_level1_i(gauss_level1),
    .gauss_level2_i(gauss_level2),
    .gauss_level3_i(gauss_level3),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .center_x_o    (center_x),
    .center_y_o    (center_y),
    .is_extremum_o (is_extremum),
    .is_maximum_o  (is_maximum)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clamp_size(logic [dogx_pkg::CFG_BITS-1:0] v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Work out the verdict (if any) for one accepted word and advance the position.
  task automatic predict_centre(input gauss_word_t w);
    int width_used;
    int height_used;
    int x;
    int y;
    dog_t cur [3];
    dog_t patch [3][3][3];
    dog_t ctr;
    logic no_higher;
    logic no_lower;
    logic ext;
    centre_verdict_t v;
    width_used  = clamp_size(cfg_width, LINE_MAX);
    height_used = clamp_size(cfg_height, HEIGHT_MAX);
    x = col_pos;
    y = row_pos;
    if (x >= width_used) x = width_used - 1;
    for (int p = 0; p < 3; p++)
      cur[p] = $signed({1'b0, w[p+1]}) - $signed({1'b0, w[p]});
    for (int p = 0; p < 3; p++) begin
      for (int r = 0; r < 3; r++) begin
        patch[p][r][0] = win[p][r][0];
        patch[p][r][1] = win[p][r][1];
      end
      patch[p][0][2] = line_two_above[x][p];
      patch[p][1][2] = line_above[x][p];
      patch[p][2][2] = cur[p];
    end
    if (x >= 2 && y >= 2) begin
      ctr = patch[1][1][1];
      no_higher = 1'b1;
      no_lower  = 1'b1;
      for (int p = 0; p < 3; p++)
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            if (!(p == 1 && r == 1 && c == 1)) begin
              if (patch[p][r][c] > ctr) no_higher = 1'b0;
              if (patch[p][r][c] < ctr) no_lower = 1'b0;
            end
      // both true means a flat neighbourhood: no extremum
      ext    = no_higher != no_lower;
      v.cx   = dogx_pkg::POS_BITS'(x - 1);
      v.cy   = dogx_pkg::POS_BITS'(y - 1);
      v.ext  = ext;
      v.maxm = ext & no_higher;
      expected_verdicts.push_back(v);
    end
    for (int p = 0; p < 3; p++) begin
      for (int r = 0; r < 3; r++) begin
        win[p][r][0] = patch[p][r][1];
        win[p][r][1] = patch[p][r][2];
      end
      line_two_above[x][p] = line_above[x][p];
      line_above[x][p]     = cur[p];
    end
    if (x + 1 >= width_used) begin
      col_pos = 0;
      row_pos = (y + 1 >= height_used) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      if (y >= height_used) row_pos = height_used - 1;
    end
  endtask

  function automatic gauss_word_t make_word(fill_t fill);
    gauss_word_t w;
    int roll;
    w = '0;
    case (fill)
      FILL_NOISE: begin
        w = {$urandom(), $urandom()};
      end
      FILL_TIES: begin
        for (int i = 0; i < 4; i++) w[i] = frame_base[i] + 16'($urandom_range(2));
      end
      FILL_FLAT: begin
        w = frame_base;
      end
      FILL_SPIKES: begin
        // sparse spikes in the middle levels make peaks and dips in the centre plane
        w = frame_base;
        roll = $urandom_range(11);
        if (roll == 0) w[2] = 16'($urandom());
        else if (roll == 1) w[1] = 16'($urandom());
      end
      FILL_PEAK: begin
        if (col_pos == 1 && row_pos == 1) w[2] = 16'hFFFF;
      end
      FILL_DIP: begin
        if (col_pos == 1 && row_pos == 1) w[1] = 16'hFFFF;
        else if (col_pos == 0 && row_pos == 0) w[0] = 16'hFFFF;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  task automatic send_word(input gauss_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    gauss_level0 <= w[0];
    gauss_level1 <= w[1];
    gauss_level2 <= w[2];
    gauss_level3 <= w[3];
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_centre(w);
    words_sent++;
  endtask

  // Send words until the position wraps back to the start of a frame.
  task automatic send_frame(input fill_t fill);
    do send_word(make_word(fill));
    while (!(col_pos == 0 && row_pos == 0));
  endtask

  // Drop valid, wait for every verdict, then let words without a result drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dogx_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [dogx_pkg::CFG_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == dogx_pkg::CFG_LINE_WIDTH) cfg_width = data;
    else if (idx == dogx_pkg::CFG_FRAME_HEIGHT) cfg_height = data;
    @(posedge clk_i);
  endtask

  task automatic set_size(input logic [dogx_pkg::CFG_BITS-1:0] w,
                          input logic [dogx_pkg::CFG_BITS-1:0] h);
    wait_idle();
    write_reg(dogx_pkg::CFG_LINE_WIDTH, w);
    write_reg(dogx_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  task automatic check_verdict();
    centre_verdict_t want;
    centre_verdict_t got;
    got.cx   = center_x;
    got.cy   = center_y;
    got.ext  = is_extremum;
    got.maxm = is_maximum;
    if (expected_verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: x=%0d y=%0d ext=%0b max=%0b",
                 got.cx, got.cy, got.ext, got.maxm);
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.cx !== want.cx || got.cy !== want.cy || got.ext !== want.ext ||
        got.maxm !== want.maxm) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected x=%0d y=%0d ext=%0b max=%0b, %s x=%0d y=%0d ext=%0b max=%0b",
                 want.cx, want.cy, want.ext, want.maxm, "got",
                 got.cx, got.cy, got.ext, got.maxm);
    end
  endtask

  // Result side: check on each accepted word, then pick ready for the next edge.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && out_ready) check_verdict();
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Flat, peak and dip patches on the smallest frame; sizes below range clamp to 3.
  task automatic test_directed_patterns();
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    set_size(13'd2, 13'd0);
    frame_base = {4{16'hFFFF}};
    send_frame(FILL_FLAT);
    send_frame(FILL_PEAK);
    send_frame(FILL_DIP);
  endtask

  // Shrink width and height while the position sits past the new end.
  task automatic test_mid_frame_change();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_size(13'd10, 13'd6);
    frame_base = {$urandom(), $urandom()};
    send_frame(FILL_SPIKES);
    repeat (27) send_word(make_word(FILL_NOISE));
    wait_idle();
    write_reg(dogx_pkg::CFG_LINE_WIDTH, 13'd5);
    repeat (11) send_word(make_word(FILL_NOISE));
    wait_idle();
    write_reg(dogx_pkg::CFG_FRAME_HEIGHT, 13'd3);
    send_frame(FILL_NOISE);
  endtask

  task automatic test_random_frames();
    int send_pct [4] = '{0, 58, 0, 11};
    int recv_pct [4] = '{0, 0, 58, 11};
    int target;
    int pick;
    fill_t fill;
    logic [dogx_pkg::CFG_BITS-1:0] w;
    logic [dogx_pkg::CFG_BITS-1:0] h;
    target = words_sent;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      target += RANDOM_WORDS / 4;
      while (words_sent < target) begin
        pick = $urandom_range(9);
        if (pick == 0) w = dogx_pkg::CFG_BITS'($urandom_range(2));
        else if (pick == 1) w = dogx_pkg::CFG_BITS'($urandom_range(13, 40));
        else w = dogx_pkg::CFG_BITS'($urandom_range(3, 12));
        h = ($urandom_range(9) == 0) ? dogx_pkg::CFG_BITS'($urandom_range(2))
                                     : dogx_pkg::CFG_BITS'($urandom_range(3, 8));
        pick = $urandom_range(99);
        if (pick < 60) fill = FILL_SPIKES;
        else if (pick < 80) fill = FILL_TIES;
        else if (pick < 95) fill = FILL_NOISE;
        else fill = FILL_FLAT;
        frame_base = {$urandom(), $urandom()};
        set_size(w, h);
        send_frame(fill);
      end
    end
  endtask

  // Hold the result side off long enough for the block to stall its input.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_size(13'd10, 13'd10);
    frame_base = {$urandom(), $urandom()};
    hold_off = HOLD_OFF_LONG;
    send_frame(FILL_SPIKES);
  endtask

  // Start a line wider than the store allows; the next size change cuts it short.
  task automatic test_widest_line();
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    set_size(13'h1FFF, 13'd3);
    frame_base = {$urandom(), $urandom()};
    repeat (WIDE_WORDS) send_word(make_word(FILL_SPIKES));
  endtask

  // Narrow the line mid-row, then run the top rows of the tallest frame.
  task automatic test_tallest_frame();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_size(13'd3, 13'd4096);
    frame_base = {$urandom(), $urandom()};
    repeat (3 * TALL_ROWS) send_word(make_word(FILL_SPIKES));
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= dogx_pkg::CFG_LINE_WIDTH;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    gauss_level0 <= '0;
    gauss_level1 <= '0;
    gauss_level2 <= '0;
    gauss_level3 <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_patterns();
    test_mid_frame_change();
    test_random_frames();
    test_backpressure();
    test_widest_line();
    test_tallest_frame();
    wait_idle();
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
